// ===== rtl/iconv_pkg.sv =====
`timescale 1ns / 1ps

package iconv_pkg;

   localparam int MAX_LINE     = 1024;
   localparam int HEIGHT_LIMIT = 1024;
   localparam int LINE_AW      = $clog2(MAX_LINE);
   localparam int ROW_AW       = $clog2(HEIGHT_LIMIT);
   localparam int PIX_W        = 8;
   localparam int POS_W        = 10;
   localparam int SIZE_W       = 11;
   // wide enough for the clamped sizes and for the counters plus one
   localparam int CNT_W        = (LINE_AW + 1 > SIZE_W) ? LINE_AW + 1 : SIZE_W;
   localparam int COLUMN_W     = 3 * PIX_W;

   localparam int QUEUE_DEPTH  = 4;
   localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);

   localparam int CSR_IDX_W    = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_MODE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd2;

   localparam logic KERNEL_COL_DIFF  = 1'b0;
   localparam logic KERNEL_LAPLACIAN = 1'b1;

   localparam logic [SIZE_W-1:0] WIDTH_RESET  = 11'd1000;
   localparam logic [SIZE_W-1:0] HEIGHT_RESET = 11'd500;

   // one complete window with its centre position
   typedef struct packed {
      logic [COLUMN_W-1:0] col_a;   // oldest column
      logic [COLUMN_W-1:0] col_b;   // centre column
      logic [COLUMN_W-1:0] col_d;   // newest column
      logic [POS_W-1:0]    row;
      logic [POS_W-1:0]    col;
      logic                last;
   } window_type;

   function automatic logic [CNT_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input int unsigned hi);
      logic [CNT_W-1:0] wide;
      wide = CNT_W'(v);
      if (wide < CNT_W'(3)) return CNT_W'(3);
      if (wide > CNT_W'(hi)) return CNT_W'(hi);
      return wide;
   endfunction

endpackage

// ===== rtl/iconv_front.sv =====
`timescale 1ns / 1ps

module iconv_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   output logic                           full,
   input  logic [iconv_pkg::PIX_W-1:0]    req_pixel,
   input  logic [iconv_pkg::SIZE_W-1:0]   frame_width,
   input  logic [iconv_pkg::SIZE_W-1:0]   frame_height,
   input  logic [iconv_pkg::QUEUE_AW:0]   q_level,
   output logic                           q_push,
   output iconv_pkg::window_type          q_data
);

   logic [15:0] line_mem [iconv_pkg::MAX_LINE];

   logic                              accept;
   logic [iconv_pkg::CNT_W-1:0]       w_eff;
   logic [iconv_pkg::CNT_W-1:0]       h_eff;
   logic [iconv_pkg::CNT_W-1:0]       c_wide;
   logic [iconv_pkg::CNT_W-1:0]       r_wide;
   logic [iconv_pkg::CNT_W-1:0]       cb_wide;
   logic [iconv_pkg::CNT_W-1:0]       rb_wide;
   logic [iconv_pkg::QUEUE_AW+1:0]    fill;
   logic [iconv_pkg::COLUMN_W-1:0]    new_col;
   logic                              emit;

   logic [iconv_pkg::LINE_AW-1:0]     col_ff, col_in;
   logic [iconv_pkg::ROW_AW-1:0]      row_ff, row_in;
   logic                              valid_b_ff;
   logic [iconv_pkg::LINE_AW-1:0]     col_b_ff;
   logic [iconv_pkg::ROW_AW-1:0]      row_b_ff;
   logic [iconv_pkg::PIX_W-1:0]       pix_b_ff;
   logic [15:0]                       rd_ff;
   logic [iconv_pkg::COLUMN_W-1:0]    win1_ff, win1_in;
   logic [iconv_pkg::COLUMN_W-1:0]    win2_ff, win2_in;

   // room check counts the beat still in the second stage
   assign fill   = (iconv_pkg::QUEUE_AW+2)'(q_level) + (iconv_pkg::QUEUE_AW+2)'(valid_b_ff);
   assign full   = fill >= (iconv_pkg::QUEUE_AW+2)'(iconv_pkg::QUEUE_DEPTH);
   assign accept = push && !full;

   assign w_eff  = iconv_pkg::clamp_size(frame_width, iconv_pkg::MAX_LINE);
   assign h_eff  = iconv_pkg::clamp_size(frame_height, iconv_pkg::HEIGHT_LIMIT);
   assign c_wide = iconv_pkg::CNT_W'(col_ff);
   assign r_wide = iconv_pkg::CNT_W'(row_ff);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (c_wide + 1'b1 >= w_eff) begin
            col_in = '0;
            row_in = (r_wide + 1'b1 >= h_eff) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         valid_b_ff <= 1'b0;
         win1_ff    <= '0;
         win2_ff    <= '0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         valid_b_ff <= accept;
         win1_ff    <= win1_in;
         win2_ff    <= win2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         col_b_ff <= col_ff;
         row_b_ff <= row_ff;
         pix_b_ff <= req_pixel;
      end
   end

   // line store: two lines up in the high byte, one line up in the low byte
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff <= line_mem[col_ff];
      end
      if (valid_b_ff) begin
         line_mem[col_b_ff] <= {rd_ff[7:0], pix_b_ff};
      end
   end

   assign new_col = {rd_ff[15:8], rd_ff[7:0], pix_b_ff};
   assign win1_in = valid_b_ff ? win2_ff : win1_ff;
   assign win2_in = valid_b_ff ? new_col : win2_ff;

   assign cb_wide = iconv_pkg::CNT_W'(col_b_ff);
   assign rb_wide = iconv_pkg::CNT_W'(row_b_ff);
   assign emit    = (rb_wide >= iconv_pkg::CNT_W'(2)) && (cb_wide >= iconv_pkg::CNT_W'(2))
                 && (rb_wide < h_eff) && (cb_wide < w_eff);

   assign q_push       = valid_b_ff && emit;
   assign q_data.col_a = win1_ff;
   assign q_data.col_b = win2_ff;
   assign q_data.col_d = new_col;
   assign q_data.row   = iconv_pkg::POS_W'(row_b_ff - 1'b1);
   assign q_data.col   = iconv_pkg::POS_W'(col_b_ff - 1'b1);
   assign q_data.last  = (rb_wide == h_eff - 1'b1) && (cb_wide == w_eff - 1'b1);

   // the store write of one beat never lands where the next beat reads
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (accept && valid_b_ff) |-> (col_ff != col_b_ff))
      else $error("line store read and write hit the same column");

   a_col_in_line: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (cb_wide < w_eff && rb_wide < h_eff))
      else $error("window pushed from outside the frame");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (q_level < (iconv_pkg::QUEUE_AW+1)'(iconv_pkg::QUEUE_DEPTH)))
      else $error("window pushed into a full queue");

endmodule

// ===== rtl/iconv_queue.sv =====
`timescale 1ns / 1ps

module iconv_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_push,
   input  iconv_pkg::window_type        q_wdata,
   input  logic                         q_pop,
   output iconv_pkg::window_type        q_rdata,
   output logic                         q_nonempty,
   output logic [iconv_pkg::QUEUE_AW:0] q_level
);

   iconv_pkg::window_type slot_ff [iconv_pkg::QUEUE_DEPTH];

   logic [iconv_pkg::QUEUE_AW-1:0] wptr_ff, wptr_in;
   logic [iconv_pkg::QUEUE_AW-1:0] rptr_ff, rptr_in;
   logic [iconv_pkg::QUEUE_AW:0]   count_ff, count_in;

   assign wptr_in  = q_push ? wptr_ff + 1'b1 : wptr_ff;
   assign rptr_in  = q_pop  ? rptr_ff + 1'b1 : rptr_ff;
   assign count_in = count_ff + (iconv_pkg::QUEUE_AW+1)'(q_push)
                             - (iconv_pkg::QUEUE_AW+1)'(q_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push) begin
         slot_ff[wptr_ff] <= q_wdata;
      end
   end

   assign q_rdata    = slot_ff[rptr_ff];
   assign q_nonempty = count_ff != '0;
   assign q_level    = count_ff;

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_nonempty)
      else $error("pop from empty queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (iconv_pkg::QUEUE_AW+1)'(iconv_pkg::QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (count_ff != (iconv_pkg::QUEUE_AW+1)'(iconv_pkg::QUEUE_DEPTH))
         |-> (iconv_pkg::QUEUE_AW'(wptr_ff - rptr_ff) == iconv_pkg::QUEUE_AW'(count_ff)))
      else $error("queue pointers disagree with count");

endmodule

// ===== rtl/iconv_back.sv =====
`timescale 1ns / 1ps

module iconv_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        kernel_mode,
   input  iconv_pkg::window_type       q_rdata,
   input  logic                        q_nonempty,
   output logic                        q_pop,
   output logic                        empty,
   input  logic                        pop,
   output logic [iconv_pkg::PIX_W-1:0] rsp_out_pixel,
   output logic [iconv_pkg::POS_W-1:0] rsp_out_row,
   output logic [iconv_pkg::POS_W-1:0] rsp_out_col,
   output logic                        rsp_out_last
);

   logic                        take;
   logic [iconv_pkg::PIX_W-1:0] a_t, a_m, a_b, b_t, b_m, b_b, d_t, d_m, d_b;
   logic [iconv_pkg::PIX_W-1:0] sum;

   logic                        valid_ff, valid_in;
   logic [iconv_pkg::PIX_W-1:0] pix_ff;
   logic [iconv_pkg::POS_W-1:0] row_ff;
   logic [iconv_pkg::POS_W-1:0] col_ff;
   logic                        last_ff;

   assign {a_t, a_m, a_b} = q_rdata.col_a;
   assign {b_t, b_m, b_b} = q_rdata.col_b;
   assign {d_t, d_m, d_b} = q_rdata.col_d;

   // all terms wrap at 8 bits, same as the low byte of the full sum
   always_comb begin
      case (kernel_mode)
         iconv_pkg::KERNEL_COL_DIFF:  sum = (a_t + a_m + a_b) - (d_t + d_m + d_b);
         iconv_pkg::KERNEL_LAPLACIAN: sum = {b_m[5:0], 2'b00} - b_t - b_b - a_m - d_m;
         default:                     sum = '0;
      endcase
   end

   assign take     = q_nonempty && (!valid_ff || pop);
   assign q_pop    = take;
   assign valid_in = take ? 1'b1 : (pop ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         pix_ff  <= sum;
         row_ff  <= q_rdata.row;
         col_ff  <= q_rdata.col;
         last_ff <= q_rdata.last;
      end
   end

   assign empty         = !valid_ff;
   assign rsp_out_pixel = pix_ff;
   assign rsp_out_row   = row_ff;
   assign rsp_out_col   = col_ff;
   assign rsp_out_last  = last_ff;

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !pop) |=> (valid_ff && $stable(row_ff) && $stable(col_ff)))
      else $error("result register changed while stalled");

   a_take_room: assert property (@(posedge clock) disable iff (reset)
      take |-> (!valid_ff || pop))
      else $error("result register overwritten");

   a_fill_after_take: assert property (@(posedge clock) disable iff (reset)
      take |=> valid_ff)
      else $error("taken window lost");

endmodule

// ===== rtl/image_3x3_convolution_top.sv =====
`timescale 1ns / 1ps

// channel  | direction | handshake           | payload
// req      | in        | push / full         | req_pixel
// rsp      | out       | empty / pop         | rsp_out_pixel, rsp_out_row, rsp_out_col,
//          |           |                     | rsp_out_last
// csr      | in        | csr_we              | csr_index, csr_wdata
//
// one pixel per clock sustained while full stays low; a result reaches the rsp ports through
// the line store read stage, the window queue, then the result register
// the line store has one read and one write port, which sets the one pixel per clock
// reset is synchronous and clears counters, window, queue and result valid; no clearing pass
// a stalled rsp fills the result register and the four-entry window queue, counting the
// window in the read stage, then full rises

module image_3x3_convolution_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   output logic                            full,
   input  logic [iconv_pkg::PIX_W-1:0]     req_pixel,
   output logic                            empty,
   input  logic                            pop,
   output logic [iconv_pkg::PIX_W-1:0]     rsp_out_pixel,
   output logic [iconv_pkg::POS_W-1:0]     rsp_out_row,
   output logic [iconv_pkg::POS_W-1:0]     rsp_out_col,
   output logic                            rsp_out_last,
   input  logic                            csr_we,
   input  logic [iconv_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [iconv_pkg::SIZE_W-1:0]    csr_wdata
);

   logic                          kernel_mode_ff;
   logic [iconv_pkg::SIZE_W-1:0]  frame_width_ff;
   logic [iconv_pkg::SIZE_W-1:0]  frame_height_ff;

   logic                          q_push;
   logic                          q_pop;
   logic                          q_nonempty;
   logic [iconv_pkg::QUEUE_AW:0]  q_level;
   iconv_pkg::window_type         q_wdata;
   iconv_pkg::window_type         q_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_mode_ff  <= iconv_pkg::KERNEL_COL_DIFF;
         frame_width_ff  <= iconv_pkg::WIDTH_RESET;
         frame_height_ff <= iconv_pkg::HEIGHT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            iconv_pkg::CSR_KERNEL_MODE:  kernel_mode_ff  <= csr_wdata[0];
            iconv_pkg::CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata;
            iconv_pkg::CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   iconv_front u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .req_pixel    (req_pixel),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .q_level      (q_level),
      .q_push       (q_push),
      .q_data       (q_wdata)
   );

   iconv_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .q_push     (q_push),
      .q_wdata    (q_wdata),
      .q_pop      (q_pop),
      .q_rdata    (q_rdata),
      .q_nonempty (q_nonempty),
      .q_level    (q_level)
   );

   iconv_back u_back (
      .clock         (clock),
      .reset         (reset),
      .kernel_mode   (kernel_mode_ff),
      .q_rdata       (q_rdata),
      .q_nonempty    (q_nonempty),
      .q_pop         (q_pop),
      .empty         (empty),
      .pop           (pop),
      .rsp_out_pixel (rsp_out_pixel),
      .rsp_out_row   (rsp_out_row),
      .rsp_out_col   (rsp_out_col),
      .rsp_out_last  (rsp_out_last)
   );

endmodule

// ===== test/tb_image_3x3_convolution_top.sv =====
`timescale 1ns / 1ps

module tb_image_3x3_convolution_top;

   import iconv_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 600000;
   localparam int          DRAIN_CYCLES = 10;
   localparam int          PHASE_PIXELS = 210;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_INDEX = 2'd3;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      logic             last;
   } conv_result_type;

   localparam conv_result_type NO_RESULT = '0;

   typedef enum logic {STEP_CSR, STEP_PIXEL} step_kind_type;

   typedef struct {
      step_kind_type        kind;
      logic [CSR_IDX_W-1:0] index;
      logic [SIZE_W-1:0]    value;
      bit                   typed;
      conv_result_type      result;
   } step_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 push = 1'b0;
   logic                 full;
   logic [PIX_W-1:0]     req_pixel = '0;
   logic                 empty;
   logic                 pop = 1'b0;
   logic [PIX_W-1:0]     rsp_out_pixel;
   logic [POS_W-1:0]     rsp_out_row;
   logic [POS_W-1:0]     rsp_out_col;
   logic                 rsp_out_last;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [SIZE_W-1:0]    csr_wdata = '0;

   // predictor state
   logic [PIX_W-1:0]    line_above     [0:MAX_LINE-1];
   logic [PIX_W-1:0]    line_two_above [0:MAX_LINE-1];
   logic [COLUMN_W-1:0] win_cols [0:2] = '{default: '0};
   int unsigned         row_pos = 0;
   int unsigned         col_pos = 0;
   logic                kernel_sel = KERNEL_COL_DIFF;
   logic [SIZE_W-1:0]   width_setting = WIDTH_RESET;
   logic [SIZE_W-1:0]   height_setting = HEIGHT_RESET;

   conv_result_type awaited_results [$];
   step_type        directed_steps [$];
   int              mismatch_count = 0;
   int unsigned     pixels_accepted = 0;
   int unsigned     cycle_count = 0;
   int              send_idle_pct = 0;
   int              recv_idle_pct = 0;

   image_3x3_convolution_top u_dut (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_pixel     (req_pixel),
      .empty         (empty),
      .pop           (pop),
      .rsp_out_pixel (rsp_out_pixel),
      .rsp_out_row   (rsp_out_row),
      .rsp_out_col   (rsp_out_col),
      .rsp_out_last  (rsp_out_last),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // shifts the window, updates the line stores and gives the kernel sum
   // for the centre when the window is complete
   function automatic bit convolve_pixel(input logic [PIX_W-1:0] px,
                                         output conv_result_type res);
      int unsigned         eff_w, eff_h, r, c;
      logic [PIX_W-1:0]    up1, up2;
      logic [COLUMN_W-1:0] ca, cb, cd;
      int                  acc;
      bit                  hit;
      eff_w = (width_setting < 3) ? 3 : (width_setting > MAX_LINE) ? MAX_LINE : width_setting;
      eff_h = (height_setting < 3) ? 3 :
              (height_setting > HEIGHT_LIMIT) ? HEIGHT_LIMIT : height_setting;
      r = row_pos;
      c = col_pos;
      res = NO_RESULT;
      hit = 1'b0;
      up1 = '0;
      up2 = '0;
      if (c < MAX_LINE) begin
         up1 = line_above[LINE_AW'(c)];
         up2 = line_two_above[LINE_AW'(c)];
      end
      win_cols[0] = win_cols[1];
      win_cols[1] = win_cols[2];
      win_cols[2] = {up2, up1, px};
      if (c < MAX_LINE) begin
         line_two_above[LINE_AW'(c)] = up1;
         line_above[LINE_AW'(c)] = px;
      end
      if (r >= 2 && c >= 2 && r < eff_h && c < eff_w) begin
         ca = win_cols[0];
         cb = win_cols[1];
         cd = win_cols[2];
         if (kernel_sel == KERNEL_COL_DIFF) begin
            acc = int'(ca[23:16]) + int'(ca[15:8]) + int'(ca[7:0])
                - int'(cd[23:16]) - int'(cd[15:8]) - int'(cd[7:0]);
         end else begin
            acc = 4 * int'(cb[15:8]) - int'(cb[23:16]) - int'(cb[7:0])
                - int'(ca[15:8]) - int'(cd[15:8]);
         end
         res.pixel = acc[7:0];
         res.row = POS_W'(r - 1);
         res.col = POS_W'(c - 1);
         res.last = (r == eff_h - 1) && (c == eff_w - 1);
         hit = 1'b1;
      end
      // a counter left past the frame by a size change wraps here
      if (c + 1 >= eff_w) begin
         col_pos = 0;
         row_pos = (r + 1 >= eff_h) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
      end
      return hit;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
   endtask

   always @(posedge clock) begin
      conv_result_type want;
      if (!reset && pop && !empty) begin
         if (awaited_results.size() == 0) begin
            report_mismatch($sformatf("result beat with nothing pending: row %0d col %0d",
                                      rsp_out_row, rsp_out_col));
         end else begin
            want = awaited_results.pop_front();
            check_field("out_pixel", 16'(rsp_out_pixel), 16'(want.pixel));
            check_field("out_row", 16'(rsp_out_row), 16'(want.row));
            check_field("out_col", 16'(rsp_out_col), 16'(want.col));
            check_field("out_last", 16'(rsp_out_last), 16'(want.last));
         end
      end
      pop <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   function automatic step_type csr_step(input logic [CSR_IDX_W-1:0] idx,
                                         input logic [SIZE_W-1:0] val);
      step_type s;
      s.kind = STEP_CSR;
      s.index = idx;
      s.value = val;
      s.typed = 1'b0;
      s.result = NO_RESULT;
      return s;
   endfunction

   function automatic step_type pixel_step(input logic [PIX_W-1:0] px, input bit typed,
                                           input conv_result_type res);
      step_type s;
      s.kind = STEP_PIXEL;
      s.index = CSR_KERNEL_MODE;
      s.value = SIZE_W'(px);
      s.typed = typed;
      s.result = res;
      return s;
   endfunction

   function automatic void add_step(input step_type s);
      directed_steps.insert(directed_steps.size(), s);
   endfunction

   function automatic logic [PIX_W-1:0] random_pixel();
      if ($urandom_range(0, 7) == 0)
         return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      return PIX_W'($urandom);
   endfunction

   // hold the sender until every pending result is out and the pipe is empty
   task automatic wait_drained();
      push <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
      wait_drained();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_KERNEL_MODE:  kernel_sel = val[0];
         CSR_FRAME_WIDTH:  width_setting = val;
         CSR_FRAME_HEIGHT: height_setting = val;
         default: ;
      endcase
      csr_we <= 1'b0;
   endtask

   task automatic send_pixel(input logic [PIX_W-1:0] px, input bit typed,
                             input conv_result_type typed_res);
      conv_result_type res;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_pixel <= px;
      @(posedge clock);
      while (full) @(posedge clock);
      pixels_accepted++;
      if (convolve_pixel(px, res) || typed)
         awaited_results.insert(awaited_results.size(), typed ? typed_res : res);
   endtask

   task automatic feed_to_frame_end();
      do send_pixel(random_pixel(), 1'b0, NO_RESULT);
      while (row_pos != 0 || col_pos != 0);
   endtask

   task automatic configure_frame(input logic mode, input int unsigned w, input int unsigned h);
      csr_write(CSR_KERNEL_MODE, SIZE_W'(mode));
      csr_write(CSR_FRAME_WIDTH, SIZE_W'(w));
      csr_write(CSR_FRAME_HEIGHT, SIZE_W'(h));
   endtask

   initial begin
      int          send_idle_by_phase [3];
      int          recv_idle_by_phase [3];
      int unsigned phase_end, full_w, cut, w, h;
      send_idle_by_phase = '{14, 84, 0};
      recv_idle_by_phase = '{84, 14, 0};

      // column-difference kernel, bright left column against dark right column
      add_step(csr_step(CSR_KERNEL_MODE, SIZE_W'(KERNEL_COL_DIFF)));
      add_step(csr_step(CSR_FRAME_WIDTH, 11'd3));
      add_step(csr_step(CSR_FRAME_HEIGHT, 11'd3));
      add_step(csr_step(CSR_SPARE_INDEX, 11'h7FF));
      add_step(pixel_step(8'd255, 1'b0, NO_RESULT));
      add_step(pixel_step(8'd128, 1'b0, NO_RESULT));
      add_step(pixel_step(8'd0, 1'b0, NO_RESULT));
      add_step(pixel_step(8'd255, 1'b0, NO_RESULT));
      add_step(pixel_step(8'd1, 1'b0, NO_RESULT));
      add_step(pixel_step(8'd0, 1'b0, NO_RESULT));
      add_step(pixel_step(8'd255, 1'b0, NO_RESULT));
      add_step(pixel_step(8'd77, 1'b0, NO_RESULT));
      add_step(pixel_step(8'd0, 1'b1, conv_result_type'{8'd253, 10'd1, 10'd1, 1'b1}));
      // laplacian with sizes written below the minimum, dark centre in a bright field
      add_step(csr_step(CSR_KERNEL_MODE, SIZE_W'(KERNEL_LAPLACIAN)));
      add_step(csr_step(CSR_FRAME_WIDTH, 11'd0));
      add_step(csr_step(CSR_FRAME_HEIGHT, 11'd2));
      add_step(pixel_step(8'd255, 1'b0, NO_RESULT));
      add_step(pixel_step(8'd255, 1'b0, NO_RESULT));
      add_step(pixel_step(8'd255, 1'b0, NO_RESULT));
      add_step(pixel_step(8'd255, 1'b0, NO_RESULT));
      add_step(pixel_step(8'd0, 1'b0, NO_RESULT));
      add_step(pixel_step(8'd255, 1'b0, NO_RESULT));
      add_step(pixel_step(8'd255, 1'b0, NO_RESULT));
      add_step(pixel_step(8'd255, 1'b0, NO_RESULT));
      add_step(pixel_step(8'd255, 1'b1, conv_result_type'{8'd4, 10'd1, 10'd1, 1'b1}));

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_steps[i]) begin
         if (directed_steps[i].kind == STEP_CSR)
            csr_write(directed_steps[i].index, directed_steps[i].value);
         else
            send_pixel(directed_steps[i].value[PIX_W-1:0], directed_steps[i].typed,
                       directed_steps[i].result);
      end

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = send_idle_by_phase[phase];
         recv_idle_pct = recv_idle_by_phase[phase];
         phase_end = pixels_accepted + PHASE_PIXELS;

         // narrower line written while the column counter sits past its end
         full_w = $urandom_range(8, 12);
         configure_frame(1'($urandom_range(0, 1)), full_w, 8);
         cut = $urandom_range(5, full_w - 1);
         while (row_pos != 3 || col_pos != cut) send_pixel(random_pixel(), 1'b0, NO_RESULT);
         csr_write(CSR_FRAME_WIDTH, SIZE_W'($urandom_range(3, cut)));
         feed_to_frame_end();

         // fewer lines written while the row counter sits past the new height
         configure_frame(1'($urandom_range(0, 1)), $urandom_range(4, 8), 8);
         while (row_pos != 5 || col_pos != 0) send_pixel(random_pixel(), 1'b0, NO_RESULT);
         csr_write(CSR_FRAME_HEIGHT, SIZE_W'($urandom_range(3, 5)));
         feed_to_frame_end();

         while (pixels_accepted < phase_end) begin
            if ($urandom_range(0, 3) != 0) begin
               w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
               h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
               configure_frame(1'($urandom_range(0, 1)), w, h);
            end
            feed_to_frame_end();
         end

         if (phase == 2) begin
            // width above the maximum: the first line wraps at the longest line,
            // then a narrow width finishes the frame
            configure_frame(1'($urandom_range(0, 1)), 32'd2047, 32'd3);
            while (row_pos != 1 || col_pos != 0) send_pixel(random_pixel(), 1'b0, NO_RESULT);
            csr_write(CSR_FRAME_WIDTH, SIZE_W'($urandom_range(3, 12)));
            feed_to_frame_end();
            // height above the maximum, cut short once a few lines are through
            configure_frame(1'($urandom_range(0, 1)), $urandom_range(3, 12), 32'd2047);
            while (row_pos != 5 || col_pos != 0) send_pixel(random_pixel(), 1'b0, NO_RESULT);
            csr_write(CSR_FRAME_HEIGHT, SIZE_W'($urandom_range(3, 5)));
            feed_to_frame_end();
         end
      end

      wait_drained();
      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
